@@ rtl/ftsm_pkg.sv @@
package ftsm_pkg;

    localparam int DEPTH   = 64;
    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int SUM_W   = 16 + AW;
    localparam int ACC_W   = 48 + AW;
    localparam int DIV_NW  = ACC_W;
    localparam int DIV_DW  = 41;
    localparam int DIV_CNT_W = $clog2(DIV_NW + 1);

    localparam logic [15:0] MIN_RESET  = 16'd999;
    localparam logic [15:0] CNT_MAX    = 16'hFFFF;
    localparam logic [22:0] SCORE_NUM  = 23'd6553600;
    localparam logic [14:0] SCORE_LOW  = 15'd12800;
    localparam logic [15:0] DROP_LIMIT = 16'd10;

    localparam logic [1:0] REG_MONITOR_ENABLE = 2'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIVM,
        ST_VAR,
        ST_DIVV,
        ST_DIVS,
        ST_DONE
    } ftsm_state_t;

    function automatic logic [15:0] sat_inc(input logic [15:0] c);
        return (c == CNT_MAX) ? CNT_MAX : c + 16'd1;
    endfunction

endpackage

@@ rtl/ftsm_div.sv @@
module ftsm_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ftsm_pkg::DIV_NW-1:0]  dividend,
    input  logic [ftsm_pkg::DIV_DW-1:0]  divisor,
    output logic                         done,
    output logic [ftsm_pkg::DIV_NW-1:0]  quotient
);
    import ftsm_pkg::*;

    logic [DIV_DW-1:0]    rem_reg;
    logic [DIV_NW-1:0]    quo_reg;
    logic [DIV_DW-1:0]    den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DW:0]      trial;
    logic                 fits;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[DIV_NW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DIV_DW'(trial - {1'b0, den_reg}) : trial[DIV_DW-1:0];
            quo_reg <= {quo_reg[DIV_NW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/frame_time_stability_monitor.sv @@
// Frame time stability monitor.
// Input channel: in_valid / in_stall with frame_time_ms, one frame per transaction.
// Output channel: out_valid / out_stall, one result transaction per input with
// min, max, Q8 mean and, when monitor_enable is set, variance, stability score,
// drop / stable-run / anomaly counters and the overload flag (held otherwise).
// Configuration: APB-style port, monitor_enable at byte address 0 (reset 1).
// Work per frame: with monitoring on, three divisions on the shared bit-serial
// divider plus two passes over the history of fill_count entries; with it off,
// one division and one pass. The history ring is one 64 x 16 memory with a
// single read port, read once per cycle in each pass.
// One frame is processed at a time; in_stall is high from acceptance until the
// result is loaded into the output register. The next frame may be accepted
// while that result still waits on out_stall; its result is held back until
// the previous one has been taken.
// Reset clears the counters, the fill count and write pointer, sets the minimum
// to 999 and monitor_enable to 1. No memory clearing pass is needed.
module frame_time_stability_monitor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] frame_time_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] min_frame_time,
    output logic [15:0] max_frame_time,
    output logic [23:0] mean_frame_time_q8,
    output logic [39:0] variance_q8,
    output logic [14:0] stability_q8,
    output logic [15:0] frame_drops,
    output logic [15:0] stable_run,
    output logic        anomaly,
    output logic [15:0] anomaly_total,
    output logic        overloaded
);
    import ftsm_pkg::*;

    ftsm_state_t state_reg, state_next;

    logic              enable_reg;
    logic [15:0]       ring [DEPTH];
    logic [15:0]       rdata_reg;
    logic [AW-1:0]     wp_reg;
    logic [CW-1:0]     fill_reg;
    logic [CW-1:0]     issue_reg;
    logic              dv1_reg, dv2_reg;
    logic [15:0]       x_reg, min_reg, max_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [47:0]       prod_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [23:0]       mean_reg;
    logic [39:0]       var_reg;
    logic [14:0]       score_reg;
    logic [15:0]       drop_reg, stable_reg, anom_cnt_reg;
    logic              anom_reg, over_reg;
    logic              out_valid_reg;

    logic              accept, cfg_wr, issuing, pass_done, out_free;
    logic              div_start, div_done;
    logic [DIV_NW-1:0] div_n, div_q;
    logic [DIV_DW-1:0] div_d;
    logic [23:0]       v24, diff;
    logic [39:0]       var_q;
    logic              is_drop, is_anom;
    logic [15:0]       drop_new;
    logic [14:0]       score_new;

    assign accept   = in_valid && !in_stall;
    assign in_stall = state_reg != ST_IDLE;
    assign out_free = !out_valid_reg || !out_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr == REG_MONITOR_ENABLE) ? {31'd0, enable_reg} : 32'd0;

    assign issuing   = issue_reg < fill_reg;
    assign pass_done = !issuing && !dv1_reg && !dv2_reg;

    assign v24  = {rdata_reg, 8'd0};
    assign diff = (v24 >= mean_reg) ? v24 - mean_reg : mean_reg - v24;

    assign var_q     = div_q[47:8];
    assign score_new = div_q[14:0];
    assign is_drop   = {x_reg, 8'd0} > {1'b0, mean_reg, 1'b0};
    assign is_anom   = ({x_reg, 3'd0} + {2'd0, x_reg, 1'b0}) > {1'b0, max_reg, 3'd0};
    assign drop_new  = is_drop ? sat_inc(drop_reg) : drop_reg;

    always_comb
    begin
        div_n = '0;
        div_d = '0;
        unique case (state_reg)
            ST_SUM:
            begin
                div_n = DIV_NW'({sum_reg, 8'd0});
                div_d = DIV_DW'(fill_reg);
            end
            ST_VAR:
            begin
                div_n = DIV_NW'(acc_reg);
                div_d = DIV_DW'(fill_reg);
            end
            ST_DIVV:
            begin
                div_n = DIV_NW'(SCORE_NUM);
                div_d = DIV_DW'(var_q) + DIV_DW'(256);
            end
            default:
            begin
                div_n = '0;
                div_d = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_SUM;
            ST_SUM:
                if (pass_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVM;
                end
            ST_DIVM:
                if (div_done)
                    state_next = enable_reg ? ST_VAR : ST_DONE;
            ST_VAR:
                if (pass_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVV;
                end
            ST_DIVV:
                if (div_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVS;
                end
            ST_DIVS:
                if (div_done)
                    state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    ftsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    // history ring: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (accept)
            ring[wp_reg] <= frame_time_ms;
        rdata_reg <= ring[issue_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b1;
            wp_reg        <= '0;
            fill_reg      <= '0;
            issue_reg     <= '0;
            dv1_reg       <= 1'b0;
            dv2_reg       <= 1'b0;
            min_reg       <= MIN_RESET;
            max_reg       <= '0;
            var_reg       <= '0;
            score_reg     <= '0;
            drop_reg      <= '0;
            stable_reg    <= '0;
            anom_cnt_reg  <= '0;
            anom_reg      <= 1'b0;
            over_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr && paddr == REG_MONITOR_ENABLE)
                enable_reg <= pwdata[0];

            out_valid_reg <= (state_reg == ST_DONE && out_free) || (out_valid_reg && out_stall);

            dv1_reg <= issuing && (state_reg == ST_SUM || state_reg == ST_VAR);
            dv2_reg <= dv1_reg && state_reg == ST_VAR;

            unique case (state_reg)
                ST_IDLE:
                    if (accept)
                    begin
                        if (frame_time_ms < min_reg)
                            min_reg <= frame_time_ms;
                        if (frame_time_ms > max_reg)
                            max_reg <= frame_time_ms;
                        wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                        if (fill_reg != CW'(DEPTH))
                            fill_reg <= fill_reg + 1'b1;
                        issue_reg <= '0;
                    end
                ST_SUM, ST_VAR:
                    if (issuing)
                        issue_reg <= issue_reg + 1'b1;
                ST_DIVM:
                    issue_reg <= '0;
                ST_DIVV:
                    if (div_done)
                        var_reg <= var_q;
                ST_DIVS:
                    if (div_done)
                    begin
                        score_reg <= score_new;
                        drop_reg  <= drop_new;
                        stable_reg <= is_drop ? '0 : sat_inc(stable_reg);
                        anom_reg  <= is_anom;
                        if (is_anom)
                            anom_cnt_reg <= sat_inc(anom_cnt_reg);
                        over_reg  <= (score_new < SCORE_LOW) || (drop_new > DROP_LIMIT);
                    end
                default:
                    issue_reg <= issue_reg;
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg   <= frame_time_ms;
            sum_reg <= '0;
            acc_reg <= '0;
        end
        if (state_reg == ST_SUM && dv1_reg)
            sum_reg <= sum_reg + SUM_W'(rdata_reg);
        if (state_reg == ST_DIVM && div_done)
            mean_reg <= div_q[23:0];
        prod_reg <= diff * diff;
        if (state_reg == ST_VAR && dv2_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            min_frame_time     <= min_reg;
            max_frame_time     <= max_reg;
            mean_frame_time_q8 <= mean_reg;
            variance_q8        <= var_reg;
            stability_q8       <= score_reg;
            frame_drops        <= drop_reg;
            stable_run         <= stable_reg;
            anomaly            <= anom_reg;
            anomaly_total      <= anom_cnt_reg;
            overloaded         <= over_reg;
        end
    end

    assign out_valid = out_valid_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("fill count beyond ring depth");

    a_wp_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < CW'(DEPTH) |-> wp_reg == fill_reg[AW-1:0])
        else $error("write pointer out of step with fill count");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_SUM && issue_reg == '0)
        else $error("accepted frame did not start the sum pass");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside completion");

    a_no_read_past_fill: assert property (@(posedge clk) disable iff (!rst_n)
        dv1_reg |-> $past(issue_reg) < fill_reg)
        else $error("history read beyond filled entries");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import ftsm_pkg::*;

    typedef struct packed {
        logic [15:0] min_t;
        logic [15:0] max_t;
        logic [23:0] mean;
        logic [39:0] variance;
        logic [14:0] score;
        logic [15:0] drops;
        logic [15:0] run;
        logic        anom;
        logic [15:0] anom_cnt;
        logic        ovl;
    } frame_stats_t;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] frame_time_ms;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] min_frame_time, max_frame_time;
    logic [23:0] mean_frame_time_q8;
    logic [39:0] variance_q8;
    logic [14:0] stability_q8;
    logic [15:0] frame_drops, stable_run, anomaly_total;
    logic        anomaly, overloaded;

    frame_time_stability_monitor DUT (.*);

    // predictor state
    logic [15:0]  hist [DEPTH];
    int           wr_ptr, fill;
    logic [15:0]  p_min, p_max;
    logic [39:0]  p_var;
    logic [14:0]  p_score;
    logic [15:0]  p_drops, p_run, p_anom_cnt;
    logic         p_anom, p_ovl, p_enable;

    frame_stats_t stats_due [$];
    int           errors;
    int           cycles;
    int           send_idle_pct, stall_pct;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 4000000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic predictor_reset();
        wr_ptr = 0; fill = 0; p_min = MIN_RESET; p_max = 0;
        p_var = 0; p_score = 0; p_drops = 0; p_run = 0; p_anom_cnt = 0;
        p_anom = 0; p_ovl = 0; p_enable = 1;
    endtask

    function automatic logic [15:0] bump(input logic [15:0] c);
        return (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

    task automatic predict_frame(input logic [15:0] x);
        logic [63:0] total, avg, acc, v, d;
        frame_stats_t s;
        total = 0; acc = 0;
        if (x < p_min) p_min = x;
        if (x > p_max) p_max = x;
        hist[wr_ptr] = x;
        wr_ptr = (wr_ptr + 1) % DEPTH;
        if (fill < DEPTH) fill++;
        for (int i = 0; i < fill; i++)
            total += hist[i];
        avg = (total << 8) / fill;
        if (p_enable)
        begin
            for (int i = 0; i < fill; i++)
            begin
                v = 64'(hist[i]) << 8;
                d = (v >= avg) ? v - avg : avg - v;
                acc += d * d;
            end
            p_var = 40'((acc / fill) >> 8);
            p_score = 15'((64'd25600 << 8) / (64'd256 + 64'(p_var)));
            if ((64'(x) << 8) > 2 * avg)
            begin
                p_drops = bump(p_drops);
                p_run = 0;
            end
            else
                p_run = bump(p_run);
            p_anom = (10 * 64'(x) > 8 * 64'(p_max));
            if (p_anom) p_anom_cnt = bump(p_anom_cnt);
            p_ovl = (p_score < SCORE_LOW) || (p_drops > DROP_LIMIT);
        end
        s.min_t = p_min; s.max_t = p_max; s.mean = avg[23:0];
        s.variance = p_var; s.score = p_score; s.drops = p_drops; s.run = p_run;
        s.anom = p_anom; s.anom_cnt = p_anom_cnt; s.ovl = p_ovl;
        stats_due.push_back(s);
    endtask

    // valid stays up after acceptance; the next call or drain() drives it again
    task automatic send_frame(input logic [15:0] x);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        frame_time_ms <= x;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_frame(x);
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        frame_stats_t s;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (stats_due.size() == 0)
                begin
                    $display("unexpected result at %0t", $realtime);
                    errors++;
                end
                else
                begin
                    s = stats_due.pop_front();
                    if (min_frame_time !== s.min_t) report("min", min_frame_time, s.min_t);
                    if (max_frame_time !== s.max_t) report("max", max_frame_time, s.max_t);
                    if (mean_frame_time_q8 !== s.mean)
                        report("mean", mean_frame_time_q8, s.mean);
                    if (variance_q8 !== s.variance) report("variance", variance_q8, s.variance);
                    if (stability_q8 !== s.score) report("stability", stability_q8, s.score);
                    if (frame_drops !== s.drops) report("drops", frame_drops, s.drops);
                    if (stable_run !== s.run) report("stable_run", stable_run, s.run);
                    if (anomaly !== s.anom) report("anomaly", anomaly, s.anom);
                    if (anomaly_total !== s.anom_cnt)
                        report("anomaly_total", anomaly_total, s.anom_cnt);
                    if (overloaded !== s.ovl) report("overloaded", overloaded, s.ovl);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic drain();
        in_valid <= 1'b0;
        while (stats_due.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_enable(input logic val);
        drain();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= REG_MONITOR_ENABLE; pwdata <= {31'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        p_enable = val;
        @(posedge clk);
    endtask

    task automatic set_idling(input int snd, input int rcv);
        send_idle_pct = snd;
        stall_pct = rcv;
    endtask

    task automatic test_directed();
        send_frame(16'd16);
        send_frame(16'd0);
        send_frame(16'hFFFF);
        send_frame(16'd17);
        send_frame(16'd1000);
        send_frame(16'hAAAA);
        send_frame(16'h5555);
        send_frame(16'd16);
        write_enable(1'b0);
        send_frame(16'd3);
        send_frame(16'hFFFF);
        send_frame(16'd20);
        write_enable(1'b1);
        send_frame(16'd998);
        send_frame(16'd999);
    endtask

    // fills the ring past wrap-around with steady frames and spikes
    task automatic test_random(input int count);
        logic [15:0] x;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(9))
                0: x = 16'($urandom);
                1: x = 16'($urandom_range(200, 60000));
                2: x = 16'($urandom_range(0, 3));
                default: x = 16'($urandom_range(14, 20));
            endcase
            send_frame(x);
        end
    endtask

    // many short frames in a settled ring: drive the stable run well up
    task automatic test_long_run();
        for (int i = 0; i < 80; i++)
            send_frame(16'd16);
    endtask

    initial
    begin
        cycles = 0; errors = 0;
        rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_valid = 0; frame_time_ms = 0; out_stall = 0;
        set_idling(0, 0);
        predictor_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        set_idling(0, 0);
        test_random(100);
        set_idling(66, 0);
        test_random(80);
        set_idling(0, 66);
        test_random(80);
        write_enable(1'b0);
        set_idling(34, 34);
        test_random(40);
        write_enable(1'b1);
        test_random(40);
        set_idling(0, 0);
        test_long_run();
        drain();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
